/* hdl/nqpe_pkg.sv */
// ----------------------------------------------------------------------------
// nqpe_pkg: shared types and constants of the queue pair engine
// Opcodes, register indexes, the job record passed from the front to the
// back, the result record and the doorbell offset helper.
// ----------------------------------------------------------------------------
package nqpe_pkg;

   // default submission/completion queue depth
   localparam int QUEUE_DEPTH_DEF = 64;
   // widest slot index any supported depth needs
   localparam int IDX_MAX_W = 12;
   // longest transfer in sectors
   localparam logic [8:0] MAX_RUN = 9'd8;
   // first doorbell register
   localparam logic [18:0] DOORBELL_BASE = 19'h01000;
   // timeout register value after reset
   localparam logic [11:0] TIMEOUT_RESET = 12'd3002;

   // job queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   // input opcodes
   localparam logic [2:0] OP_TRANSFER   = 3'd0;
   localparam logic [2:0] OP_FLUSH      = 3'd1;
   localparam logic [2:0] OP_ADMIN      = 3'd2;
   localparam logic [2:0] OP_COMPLETION = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;
   localparam logic [2:0] OP_FATAL      = 3'd5;

   // transfer command codes
   localparam logic [7:0] CMD_WRITE = 8'd1;
   localparam logic [7:0] CMD_READ  = 8'd2;

   // queue numbers
   localparam logic QUEUE_ADMIN = 1'b0;
   localparam logic QUEUE_IO    = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_SHIFT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_TOTAL  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_PRESENT  = 2'd3;

   typedef enum logic [1:0] {
      RES_ENTRY    = 2'd0,
      RES_DOORBELL = 2'd1,
      RES_DONE     = 2'd2,
      RES_REJECT   = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      JOB_SUBMIT   = 2'd0,
      JOB_COMPLETE = 2'd1,
      JOB_FAIL     = 2'd2,
      JOB_REJECT   = 2'd3
   } job_kind_type;

   // classified work item, expands to one or two result beats
   typedef struct packed {
      job_kind_type          kind;
      logic                  queue;
      logic [IDX_MAX_W-1:0]  slot;
      logic [15:0]           id;
      logic [7:0]            opc;
      logic [31:0]           addr;
      logic [2:0]            cm1;
      logic [18:0]           db_offset;
      logic [IDX_MAX_W-1:0]  db_value;
      logic [14:0]           code;
   } job_type;

   // one result beat
   typedef struct packed {
      result_kind_type       kind;
      logic                  queue;
      logic [IDX_MAX_W-1:0]  slot;
      logic [15:0]           id;
      logic [7:0]            opc;
      logic [31:0]           addr;
      logic [2:0]            cm1;
      logic [18:0]           db_offset;
      logic [IDX_MAX_W-1:0]  db_value;
      logic                  success;
      logic [14:0]           code;
      logic                  last;
   } result_type;

   // doorbell offset: base + (2*queue + completion) * (4 << stride_shift)
   function automatic logic [18:0] bell_offset(input logic q, input logic cpl,
                                               input logic [3:0] stride_shift);
      logic [18:0] pick;
      pick = {17'd0, q, cpl};
      return DOORBELL_BASE + ((pick << stride_shift) << 2);
   endfunction

endpackage

/* hdl/nqpe_front.sv */
// ----------------------------------------------------------------------------
// nqpe_front: command front end
// Holds configuration and queue state, checks and classifies each item in
// the cycle it is accepted and hands a job record to the back end.
// ----------------------------------------------------------------------------
module nqpe_front
   import nqpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             opcode,
   input  logic [7:0]             command_code,
   input  logic [31:0]            block_address,
   input  logic [7:0]             block_count,
   input  logic [15:0]            completion_status,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output logic                   job_push,
   output job_type                job
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   // configuration registers
   logic [3:0]  stride_ff;
   logic [11:0] timeout_ff;
   logic [31:0] sectors_ff;
   logic        present_ff;

   // queue pair state
   logic [IDX_W-1:0] tail_ff [2];
   logic [IDX_W-1:0] head_ff [2];
   logic             phase_ff [2];
   logic [15:0]      next_id_ff;
   logic             busy_ff;
   logic             pend_q_ff;
   logic [15:0]      pend_id_ff;
   logic [11:0]      elapsed_ff;

   logic [IDX_W-1:0] tail_in;
   logic [IDX_W-1:0] head_in;
   logic [15:0]      next_id_in;
   logic [11:0]      elapsed_in;

   // classification
   logic        sub_go;
   logic        sub_q;
   logic [7:0]  sub_opc;
   logic [31:0] sub_addr;
   logic [2:0]  sub_cm1;
   logic        rej;
   logic        cpl;
   logic        fail;
   logic        tick_inc;
   logic        xfer_ok;
   logic [32:0] end_sector;
   logic [7:0]  cnt_m1;
   logic [15:0] id_inc;

   // transfer checks
   always_comb begin
      end_sector = {1'b0, block_address} + {25'd0, block_count};
      cnt_m1     = block_count - 8'd1;
      xfer_ok    = !busy_ff && present_ff
                   && (command_code == CMD_WRITE || command_code == CMD_READ)
                   && (block_count != 8'd0) && ({1'b0, block_count} <= MAX_RUN)
                   && (end_sector <= {1'b0, sectors_ff});
   end

   // opcode decode
   always_comb begin
      sub_go   = 1'b0;
      sub_q    = QUEUE_IO;
      sub_opc  = 8'd0;
      sub_addr = 32'd0;
      sub_cm1  = 3'd0;
      rej      = 1'b0;
      cpl      = 1'b0;
      fail     = 1'b0;
      tick_inc = 1'b0;
      case (opcode)
         OP_TRANSFER: begin
            if (xfer_ok) begin
               sub_go   = 1'b1;
               sub_opc  = command_code;
               sub_addr = block_address;
               sub_cm1  = cnt_m1[2:0];
            end else begin
               rej = 1'b1;
            end
         end
         OP_FLUSH: begin
            if (!busy_ff && present_ff) begin
               sub_go = 1'b1;
            end else begin
               rej = 1'b1;
            end
         end
         OP_ADMIN: begin
            sub_q = QUEUE_ADMIN;
            if (!busy_ff) begin
               sub_go   = 1'b1;
               sub_opc  = command_code;
               sub_addr = block_address;
            end else begin
               rej = 1'b1;
            end
         end
         OP_COMPLETION: begin
            cpl = busy_ff && (completion_status[0] == phase_ff[pend_q_ff]);
         end
         OP_TICK: begin
            if (busy_ff) begin
               if (elapsed_ff >= timeout_ff) begin
                  fail = 1'b1;
               end else begin
                  tick_inc = 1'b1;
               end
            end
         end
         OP_FATAL: begin
            fail = busy_ff;
         end
         default: begin
         end
      endcase
   end

   // next indexes and id
   always_comb begin
      tail_in    = (tail_ff[sub_q] == IDX_LAST) ? '0 : tail_ff[sub_q] + 1'b1;
      head_in    = (head_ff[pend_q_ff] == IDX_LAST) ? '0 : head_ff[pend_q_ff] + 1'b1;
      id_inc     = next_id_ff + 16'd1;
      next_id_in = (id_inc == 16'd0) ? 16'd1 : id_inc;
      elapsed_in = elapsed_ff + 12'd1;
   end

   // job record
   always_comb begin
      job      = '0;
      job_push = accept && (sub_go || rej || cpl || fail);
      if (sub_go) begin
         job.kind      = JOB_SUBMIT;
         job.queue     = sub_q;
         job.slot      = IDX_MAX_W'(tail_ff[sub_q]);
         job.id        = next_id_ff;
         job.opc       = sub_opc;
         job.addr      = sub_addr;
         job.cm1       = sub_cm1;
         job.db_offset = bell_offset(sub_q, 1'b0, stride_ff);
         job.db_value  = IDX_MAX_W'(tail_in);
      end else if (rej) begin
         job.kind  = JOB_REJECT;
         job.queue = sub_q;
      end else if (cpl) begin
         job.kind      = JOB_COMPLETE;
         job.queue     = pend_q_ff;
         job.id        = pend_id_ff;
         job.db_offset = bell_offset(pend_q_ff, 1'b1, stride_ff);
         job.db_value  = IDX_MAX_W'(head_in);
         job.code      = completion_status[15:1];
      end else begin
         job.kind  = JOB_FAIL;
         job.queue = pend_q_ff;
         job.id    = pend_id_ff;
      end
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff   <= 4'd0;
         timeout_ff  <= TIMEOUT_RESET;
         sectors_ff  <= 32'd0;
         present_ff  <= 1'b0;
         tail_ff[0]  <= '0;
         tail_ff[1]  <= '0;
         head_ff[0]  <= '0;
         head_ff[1]  <= '0;
         phase_ff[0] <= 1'b1;
         phase_ff[1] <= 1'b1;
         next_id_ff  <= 16'd1;
         busy_ff     <= 1'b0;
         pend_q_ff   <= QUEUE_ADMIN;
         pend_id_ff  <= 16'd0;
         elapsed_ff  <= 12'd0;
      end else begin
         // configuration writes
         if (csr_write) begin
            case (csr_index)
               CSR_STRIDE_SHIFT:  stride_ff  <= csr_wdata[3:0];
               CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata[11:0];
               CSR_SECTOR_TOTAL:  sectors_ff <= csr_wdata;
               CSR_DISK_PRESENT:  present_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            // new command goes out
            if (sub_go) begin
               tail_ff[sub_q] <= tail_in;
               next_id_ff     <= next_id_in;
               busy_ff        <= 1'b1;
               pend_q_ff      <= sub_q;
               pend_id_ff     <= next_id_ff;
               elapsed_ff     <= 12'd0;
            end
            // completion consumed, phase flips on wrap
            if (cpl) begin
               head_ff[pend_q_ff] <= head_in;
               if (head_in == '0) begin
                  phase_ff[pend_q_ff] <= !phase_ff[pend_q_ff];
               end
               busy_ff <= 1'b0;
            end
            if (fail) begin
               busy_ff <= 1'b0;
            end
            if (tick_inc) begin
               elapsed_ff <= elapsed_in;
            end
         end
      end
   end

endmodule

/* hdl/nqpe_fifo.sv */
// ----------------------------------------------------------------------------
// nqpe_fifo: job queue
// Short first-in first-out queue of job records between the front and the
// back end, so each side stalls on its own.
// ----------------------------------------------------------------------------
module nqpe_fifo
   import nqpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W:0]   count_ff;
   logic [FIFO_PTR_W:0]   count_in;
   logic                  push_ok;
   logic                  pop_ok;

   // status and head
   always_comb begin
      full     = (count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
      empty    = (count_ff == '0);
      push_ok  = push && !full;
      pop_ok   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];
      count_in = count_ff + (FIFO_PTR_W + 1)'(push_ok) - (FIFO_PTR_W + 1)'(pop_ok);
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/nqpe_back.sv */
// ----------------------------------------------------------------------------
// nqpe_back: result back end
// Expands each job record into its one or two result beats and holds the
// oldest beat in an output register until it is popped.
// ----------------------------------------------------------------------------
module nqpe_back
   import nqpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   input  logic       rsp_pop,
   output logic       rsp_valid,
   output result_type rsp
);

   result_type res;
   result_type rsp_ff;
   logic       valid_ff;
   logic       valid_in;
   logic       phase_ff;
   logic       phase_in;
   logic       two;
   logic       load;
   logic       take;

   // beat built from the head job
   always_comb begin
      res = '0;
      two = 1'b0;
      case (job.kind)
         JOB_SUBMIT: begin
            two       = 1'b1;
            res.queue = job.queue;
            res.last  = phase_ff;
            if (!phase_ff) begin
               res.kind = RES_ENTRY;
               res.slot = job.slot;
               res.id   = job.id;
               res.opc  = job.opc;
               res.addr = job.addr;
               res.cm1  = job.cm1;
            end else begin
               res.kind      = RES_DOORBELL;
               res.db_offset = job.db_offset;
               res.db_value  = job.db_value;
            end
         end
         JOB_COMPLETE: begin
            two       = 1'b1;
            res.queue = job.queue;
            res.last  = phase_ff;
            if (!phase_ff) begin
               res.kind      = RES_DOORBELL;
               res.db_offset = job.db_offset;
               res.db_value  = job.db_value;
            end else begin
               res.kind    = RES_DONE;
               res.id      = job.id;
               res.success = (job.code == 15'd0);
               res.code    = job.code;
            end
         end
         JOB_FAIL: begin
            res.kind  = RES_DONE;
            res.queue = job.queue;
            res.id    = job.id;
            res.last  = 1'b1;
         end
         JOB_REJECT: begin
            res.kind  = RES_REJECT;
            res.queue = job.queue;
            res.last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // output register handshake
   always_comb begin
      load     = !valid_ff || rsp_pop;
      take     = load && job_valid;
      job_pop  = take && (!two || phase_ff);
      phase_in = take ? (two && !phase_ff) : phase_ff;
      valid_in = take || (valid_ff && !load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* hdl/nvme_queue_pair_engine_unit.sv */
// ----------------------------------------------------------------------------
// nvme_queue_pair_engine_unit: admin and I/O queue pair engine
// Path: accepted item -> job queue -> output register -> first result beat.
// Throughput: one item per cycle while the job queue has room; the result port
// moves one beat per cycle while the receiver pops, so items with two results
// take two beats each. The four-entry job queue absorbs bursts.
// Reset: synchronous; clears queue state, ids, config and the job queue.
// ----------------------------------------------------------------------------
module nvme_queue_pair_engine_unit
   import nqpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command and event input
   input  logic                           push,
   output logic                           full,
   input  logic [2:0]                     req_opcode,
   input  logic [7:0]                     req_command_code,
   input  logic [31:0]                    req_block_address,
   input  logic [7:0]                     req_block_count,
   input  logic [15:0]                    req_completion_status,
   // results
   output logic                           empty,
   input  logic                           pop,
   output logic [1:0]                     rsp_result_kind,
   output logic                           rsp_queue_number,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rsp_slot_index,
   output logic [15:0]                    rsp_command_id,
   output logic [7:0]                     rsp_entry_opcode,
   output logic [31:0]                    rsp_entry_address,
   output logic [2:0]                     rsp_count_minus_one,
   output logic [18:0]                    rsp_doorbell_offset,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rsp_doorbell_value,
   output logic                           rsp_success,
   output logic [14:0]                    rsp_status_code,
   output logic                           rsp_is_last,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic       accept;
   logic       job_push;
   job_type    job_in;
   job_type    job_head;
   logic       job_empty;
   logic       job_pop;
   logic       rsp_valid;
   result_type rsp;

   // input beat taken whenever the job queue has room
   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   nqpe_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .opcode            (req_opcode),
      .command_code      (req_command_code),
      .block_address     (req_block_address),
      .block_count       (req_block_count),
      .completion_status (req_completion_status),
      .csr_write         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .job_push          (job_push),
      .job               (job_in)
   );

   nqpe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (full),
      .pop       (job_pop),
      .pop_data  (job_head),
      .empty     (job_empty)
   );

   nqpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // result ports
   assign empty               = !rsp_valid;
   assign rsp_result_kind     = rsp.kind;
   assign rsp_queue_number    = rsp.queue;
   assign rsp_slot_index      = rsp.slot[IDX_W-1:0];
   assign rsp_command_id      = rsp.id;
   assign rsp_entry_opcode    = rsp.opc;
   assign rsp_entry_address   = rsp.addr;
   assign rsp_count_minus_one = rsp.cm1;
   assign rsp_doorbell_offset = rsp.db_offset;
   assign rsp_doorbell_value  = rsp.db_value[IDX_W-1:0];
   assign rsp_success         = rsp.success;
   assign rsp_status_code     = rsp.code;
   assign rsp_is_last         = rsp.last;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the admin and I/O queue pair engine
// A shadow model of the queue pair tracks ids, slots, heads, phases and the
// pending command, and predicts every result beat of each accepted item.
// Directed corner items come first, then phases of random command sequences
// under several register settings, with random sender gaps and receiver
// stalls. Every result beat is compared field by field against the model.
// ----------------------------------------------------------------------------
module tb;
   import nqpe_pkg::*;

   // consecutive cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   // random items sent per register setting
   localparam int ITEMS_PER_SETTING = 190;
   localparam int SETTING_COUNT = 8;

   // one result beat as seen on the rsp_ ports
   typedef struct packed {
      result_kind_type kind;
      logic            qnum;
      logic [5:0]      slot;
      logic [15:0]     id;
      logic [7:0]      opc;
      logic [31:0]     addr;
      logic [2:0]      cm1;
      logic [18:0]     db_off;
      logic [5:0]      db_val;
      logic            ok;
      logic [14:0]     code;
      logic            last;
   } beat_type;

   // shadow of the queue pair: register copy, queue state, beats still due
   class qpair_shadow;
      logic [3:0]  stride;
      logic [11:0] timeout_limit;
      logic [31:0] sector_limit;
      logic        present;
      logic [5:0]  tail [2];
      logic [5:0]  head [2];
      logic        phase [2];
      logic [15:0] next_id;
      logic        busy;
      logic        pend_q;
      logic [11:0] elapsed;
      logic [15:0] pend_id;
      beat_type    due_beats [$];
      int unsigned errors;
      int unsigned beats_checked;
      int unsigned acted;
      int unsigned issued;
      int unsigned refused;
      int unsigned answered;
      int unsigned aborted;
      int unsigned flips;

      function new();
         stride = 4'd0;
         timeout_limit = TIMEOUT_RESET;
         sector_limit = 32'd0;
         present = 1'b0;
         tail[0] = 6'd0;
         tail[1] = 6'd0;
         head[0] = 6'd0;
         head[1] = 6'd0;
         phase[0] = 1'b1;
         phase[1] = 1'b1;
         next_id = 16'd1;
         busy = 1'b0;
         pend_q = 1'b0;
         elapsed = 12'd0;
         pend_id = 16'd0;
         errors = 0;
         beats_checked = 0;
         acted = 0;
         issued = 0;
         refused = 0;
         answered = 0;
         aborted = 0;
         flips = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_STRIDE_SHIFT:  stride = val[3:0];
            CSR_TIMEOUT_TICKS: timeout_limit = val[11:0];
            CSR_SECTOR_TOTAL:  sector_limit = val;
            CSR_DISK_PRESENT:  present = val[0];
            default: ;
         endcase
      endfunction

      // doorbell register offset for a queue, submission or completion side
      function logic [18:0] bell_at(logic q, logic cpl);
         logic [31:0] stride_bytes;
         stride_bytes = 32'd4 << stride;
         return 19'(32'(DOORBELL_BASE) + 32'({q, cpl}) * stride_bytes);
      endfunction

      function void add_reject(logic q);
         beat_type b;
         b = '0;
         b.kind = RES_REJECT;
         b.qnum = q;
         b.last = 1'b1;
         due_beats.push_back(b);
         refused++;
      endfunction

      // entry beat, then tail doorbell beat; the command becomes pending
      function void add_submit(logic q, logic [7:0] opc, logic [31:0] addr, logic [2:0] cm1);
         beat_type b;
         b = '0;
         b.kind = RES_ENTRY;
         b.qnum = q;
         b.slot = tail[q];
         b.id = next_id;
         b.opc = opc;
         b.addr = addr;
         b.cm1 = cm1;
         due_beats.push_back(b);
         pend_id = next_id;
         next_id = next_id + 16'd1;
         if (next_id == 16'd0) next_id = 16'd1;
         tail[q] = tail[q] + 6'd1;
         b = '0;
         b.kind = RES_DOORBELL;
         b.qnum = q;
         b.db_off = bell_at(q, 1'b0);
         b.db_val = tail[q];
         b.last = 1'b1;
         due_beats.push_back(b);
         busy = 1'b1;
         pend_q = q;
         elapsed = 12'd0;
         issued++;
      endfunction

      // timeout or fatal event ends the pending command without success
      function void add_abort();
         beat_type b;
         b = '0;
         b.kind = RES_DONE;
         b.qnum = pend_q;
         b.id = pend_id;
         b.last = 1'b1;
         due_beats.push_back(b);
         busy = 1'b0;
         aborted++;
      endfunction

      function void take_command(logic [2:0] op, logic [7:0] code, logic [31:0] lba,
                                 logic [7:0] cnt, logic [15:0] st);
         beat_type b;
         logic     q;
         case (op)
            OP_TRANSFER: begin
               acted++;
               if (busy || !present || (code != CMD_WRITE && code != CMD_READ) ||
                   cnt == 8'd0 || {1'b0, cnt} > MAX_RUN ||
                   {1'b0, lba} + {25'd0, cnt} > {1'b0, sector_limit})
                  add_reject(QUEUE_IO);
               else
                  add_submit(QUEUE_IO, code, lba, 3'(cnt - 8'd1));
            end
            OP_FLUSH: begin
               acted++;
               if (busy || !present) add_reject(QUEUE_IO);
               else add_submit(QUEUE_IO, 8'd0, 32'd0, 3'd0);
            end
            OP_ADMIN: begin
               acted++;
               if (busy) add_reject(QUEUE_ADMIN);
               else add_submit(QUEUE_ADMIN, code, lba, 3'd0);
            end
            OP_COMPLETION: begin
               q = pend_q;
               // only a matching phase bit completes the pending command
               if (busy && st[0] == phase[q]) begin
                  acted++;
                  head[q] = head[q] + 6'd1;
                  if (head[q] == 6'd0) begin
                     phase[q] = ~phase[q];
                     flips++;
                  end
                  b = '0;
                  b.kind = RES_DOORBELL;
                  b.qnum = q;
                  b.db_off = bell_at(q, 1'b1);
                  b.db_val = head[q];
                  due_beats.push_back(b);
                  b = '0;
                  b.kind = RES_DONE;
                  b.qnum = q;
                  b.id = pend_id;
                  b.ok = (st[15:1] == 15'd0);
                  b.code = st[15:1];
                  b.last = 1'b1;
                  due_beats.push_back(b);
                  busy = 1'b0;
                  answered++;
               end
            end
            OP_TICK: begin
               if (busy) begin
                  acted++;
                  if (elapsed >= timeout_limit) add_abort();
                  else elapsed = elapsed + 12'd1;
               end
            end
            OP_FATAL: begin
               if (busy) begin
                  acted++;
                  add_abort();
               end
            end
            default: ;
         endcase
      endfunction

      task flag_mismatch(string what);
         errors++;
         $display("mismatch: %0s", what);
      endtask

      task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
         if (got_v !== want_v)
            flag_mismatch($sformatf("beat %0d %0s: got 0x%0h expected 0x%0h",
                                    beats_checked, name, got_v, want_v));
      endtask

      task match_beat(beat_type got);
         beat_type want;
         beats_checked++;
         if (due_beats.size() == 0) begin
            flag_mismatch($sformatf("beat %0d arrived with nothing expected", beats_checked));
            return;
         end
         want = due_beats.pop_front();
         check_field("result_kind", got.kind, want.kind);
         check_field("queue_number", got.qnum, want.qnum);
         check_field("slot_index", got.slot, want.slot);
         check_field("command_id", got.id, want.id);
         check_field("entry_opcode", got.opc, want.opc);
         check_field("entry_address", got.addr, want.addr);
         check_field("count_minus_one", got.cm1, want.cm1);
         check_field("doorbell_offset", got.db_off, want.db_off);
         check_field("doorbell_value", got.db_val, want.db_val);
         check_field("success", got.ok, want.ok);
         check_field("status_code", got.code, want.code);
         check_field("is_last", got.last, want.last);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_command_code = '0;
   logic [31:0] req_block_address = '0;
   logic [7:0]  req_block_count = '0;
   logic [15:0] req_completion_status = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic        rsp_queue_number;
   logic [5:0]  rsp_slot_index;
   logic [15:0] rsp_command_id;
   logic [7:0]  rsp_entry_opcode;
   logic [31:0] rsp_entry_address;
   logic [2:0]  rsp_count_minus_one;
   logic [18:0] rsp_doorbell_offset;
   logic [5:0]  rsp_doorbell_value;
   logic        rsp_success;
   logic [14:0] rsp_status_code;
   logic        rsp_is_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   qpair_shadow sb;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned settings_used = 0;
   int unsigned items_sent = 0;
   // register values the stimulus is shaped around
   logic [11:0] cfg_timeout = TIMEOUT_RESET;
   logic [31:0] cfg_total = 32'd0;
   // receiver stall pattern state
   int unsigned rx_mode = 0;
   int unsigned rx_mode_left = 0;
   int unsigned rx_hold = 0;
   int unsigned rx_count = 0;

   nvme_queue_pair_engine_unit DUT (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_opcode            (req_opcode),
      .req_command_code      (req_command_code),
      .req_block_address     (req_block_address),
      .req_block_count       (req_block_count),
      .req_completion_status (req_completion_status),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_queue_number      (rsp_queue_number),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_command_id        (rsp_command_id),
      .rsp_entry_opcode      (rsp_entry_opcode),
      .rsp_entry_address     (rsp_entry_address),
      .rsp_count_minus_one   (rsp_count_minus_one),
      .rsp_doorbell_offset   (rsp_doorbell_offset),
      .rsp_doorbell_value    (rsp_doorbell_value),
      .rsp_success           (rsp_success),
      .rsp_status_code       (rsp_status_code),
      .rsp_is_last           (rsp_is_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #4 clock = ~clock;

   // handshake monitor: feed the shadow, check beats, watch for a hang
   always @(posedge clock) begin
      beat_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (push && !full)
            sb.take_command(req_opcode, req_command_code, req_block_address,
                            req_block_count, req_completion_status);
         if (pop && !empty) begin
            seen.kind = result_kind_type'(rsp_result_kind);
            seen.qnum = rsp_queue_number;
            seen.slot = rsp_slot_index;
            seen.id = rsp_command_id;
            seen.opc = rsp_entry_opcode;
            seen.addr = rsp_entry_address;
            seen.cm1 = rsp_count_minus_one;
            seen.db_off = rsp_doorbell_offset;
            seen.db_val = rsp_doorbell_value;
            seen.ok = rsp_success;
            seen.code = rsp_status_code;
            seen.last = rsp_is_last;
            sb.match_beat(seen);
         end
         if ((csr_valid && csr_ready) || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", quiet_cycles);
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // receiver: always ready, coin flips, a fixed pattern, or long stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 400);
         end else begin
            rx_mode_left--;
         end
         rx_count++;
         case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (rx_count % 5) >= 2;
            default: begin
               if (rx_hold > 0) begin
                  pop <= 1'b0;
                  rx_hold--;
               end else begin
                  pop <= 1'b1;
                  if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(5, 20);
               end
            end
         endcase
      end
   end

   // one input beat; the sender goes quiet for a while at the end of a burst
   task push_item(logic [2:0] op, logic [7:0] code, logic [31:0] lba,
                  logic [7:0] cnt, logic [15:0] st);
      push <= 1'b1;
      req_opcode <= op;
      req_command_code <= code;
      req_block_address <= lba;
      req_block_count <= cnt;
      req_completion_status <= st;
      do @(posedge clock); while (full);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         push <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 25 : 4)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 12);
      end
   endtask

   // stop sending until every due beat has been taken, then idle a little
   task drain(int margin);
      push <= 1'b0;
      @(posedge clock);
      while (sb.due_beats.size() != 0) @(posedge clock);
      repeat (margin) @(posedge clock);
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task apply_setting(logic [3:0] shift, logic [11:0] ticks, logic [31:0] total, logic pres);
      write_csr(CSR_STRIDE_SHIFT, {28'd0, shift});
      write_csr(CSR_TIMEOUT_TICKS, {20'd0, ticks});
      write_csr(CSR_SECTOR_TOTAL, total);
      write_csr(CSR_DISK_PRESENT, {31'd0, pres});
      cfg_timeout = ticks;
      cfg_total = total;
      settings_used++;
   endtask

   // mostly well-formed command lifetimes, some broken transfers and noise
   task random_sequence();
      int         pick;
      int         n;
      logic       q;
      logic [7:0] cmd;
      logic [7:0] cnt;
      logic [31:0] lba;
      logic [14:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         n = $urandom_range(0, 9);
         if (n < 4) begin
            q = QUEUE_IO;
            cnt = 8'($urandom_range(1, 8));
            if (cfg_total >= 32'(cnt) && $urandom_range(0, 9) != 0)
               lba = ($urandom_range(0, 3) == 0) ? cfg_total - 32'(cnt)
                                                 : $urandom_range(cfg_total - 32'(cnt), 0);
            else
               lba = $urandom;
            cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
            push_item(OP_TRANSFER, cmd, lba, cnt, 16'($urandom));
         end else if (n < 6) begin
            q = QUEUE_IO;
            push_item(OP_FLUSH, 8'($urandom), $urandom, 8'($urandom), 16'($urandom));
         end else begin
            q = QUEUE_ADMIN;
            push_item(OP_ADMIN, 8'($urandom), $urandom, 8'($urandom), 16'($urandom));
         end
         // events while the command is outstanding
         for (n = $urandom_range(0, 4); n > 0; n--) begin
            case ($urandom_range(0, 4))
               0: push_item(OP_COMPLETION, 8'($urandom), $urandom, 8'($urandom),
                            {15'($urandom), ~sb.phase[q]});
               1: push_item(3'($urandom_range(0, 2)), 8'($urandom), $urandom,
                            8'($urandom_range(1, 8)), 16'($urandom));
               default: push_item(OP_TICK, 8'($urandom), $urandom, 8'($urandom),
                                  16'($urandom));
            endcase
         end
         // ending: completion, fatal event, or ticks into a timeout
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            code = ($urandom_range(0, 1) == 0) ? 15'd0 : 15'($urandom);
            push_item(OP_COMPLETION, 8'($urandom), $urandom, 8'($urandom), {code, sb.phase[q]});
         end else if (pick < 17) begin
            push_item(OP_FATAL, 8'($urandom), $urandom, 8'($urandom), 16'($urandom));
         end else begin
            for (n = 0; n <= int'(cfg_timeout) + 1 && n < 8; n++)
               push_item(OP_TICK, 8'($urandom), $urandom, 8'($urandom), 16'($urandom));
         end
      end else if (pick < 85) begin
         cmd = CMD_READ;
         cnt = 8'($urandom_range(1, 8));
         lba = 32'($urandom_range(0, 64));
         case ($urandom_range(0, 3))
            0: cmd = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
            1: cnt = 8'd0;
            2: cnt = 8'($urandom_range(9, 255));
            default: lba = cfg_total - 32'(cnt) + 32'($urandom_range(1, 8));
         endcase
         push_item(OP_TRANSFER, cmd, lba, cnt, 16'($urandom));
      end else begin
         push_item(3'($urandom_range(0, 7)), 8'($urandom), $urandom, 8'($urandom),
                   16'($urandom));
      end
   endtask

   initial begin
      int          ph;
      int unsigned start_sent;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: namespace absent, idle events, admin life cycle
      push_item(OP_TRANSFER, CMD_WRITE, 32'd0, 8'd1, 16'h0000);
      push_item(OP_FLUSH, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_TICK, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_FATAL, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_COMPLETION, 8'h00, 32'd0, 8'd0, 16'h0001);
      push_item(3'd6, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      push_item(3'd7, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_ADMIN, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      push_item(OP_ADMIN, 8'h06, 32'd0, 8'd0, 16'h0000);
      push_item(OP_TRANSFER, CMD_READ, 32'd0, 8'd1, 16'h0000);
      push_item(OP_COMPLETION, 8'h00, 32'd0, 8'd0, 16'hFFFE);
      push_item(OP_COMPLETION, 8'h00, 32'd0, 8'd0, 16'hFFFF);
      drain(8);

      // widest stride, zero timeout, full namespace: transfer checks
      apply_setting(4'd15, 12'd0, 32'hFFFF_FFFF, 1'b1);
      push_item(OP_TRANSFER, 8'h00, 32'd0, 8'd1, 16'h0000);
      push_item(OP_TRANSFER, 8'hFF, 32'd0, 8'd1, 16'h0000);
      push_item(OP_TRANSFER, CMD_WRITE, 32'd0, 8'd0, 16'h0000);
      push_item(OP_TRANSFER, CMD_READ, 32'd0, 8'd9, 16'h0000);
      push_item(OP_TRANSFER, CMD_READ, 32'hFFFF_FFF8, 8'd8, 16'h0000);
      push_item(OP_TRANSFER, CMD_READ, 32'hFFFF_FFF7, 8'd8, 16'h0000);
      push_item(OP_TICK, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
      push_item(OP_FATAL, 8'h00, 32'd0, 8'd0, 16'h0000);
      push_item(OP_ADMIN, 8'h06, 32'h0000_0001, 8'd0, 16'h0000);
      push_item(OP_COMPLETION, 8'h00, 32'd0, 8'd0, 16'h0001);

      // random phases, each under its own register setting
      for (ph = 0; ph < SETTING_COUNT; ph++) begin
         drain(8);
         case (ph)
            0: apply_setting(4'd0, 12'd0, 32'd0, 1'b1);
            1: apply_setting(4'd15, 12'd4095, 32'hFFFF_FFFF, 1'b1);
            2: apply_setting(4'd3, 12'd2, 32'd64, 1'b0);
            default: apply_setting(4'($urandom_range(0, 15)), 12'($urandom_range(0, 6)),
                                   ($urandom_range(0, 3) == 0)
                                      ? 32'hFFFF_FFFF - 32'($urandom_range(0, 8))
                                      : 32'($urandom_range(8, 5000)),
                                   1'b1);
         endcase
         start_sent = items_sent;
         while (items_sent - start_sent < ITEMS_PER_SETTING) begin
            random_sequence();
            // hold off now and then until everything has come back
            if ($urandom_range(0, 49) == 0) drain(0);
         end
      end

      drain(10);
      $display("covered %0d items under %0d register settings: %0d commands issued,",
               items_sent, settings_used, sb.issued);
      $display("%0d rejected, %0d completed, %0d aborted, %0d phase flips, %0d beats checked",
               sb.refused, sb.answered, sb.aborted, sb.flips, sb.beats_checked);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
